// ===== design/stack_vm_instruction_executor_unit_macros.svh =====
// Assertion macros for the stack machine executor.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef STACK_VM_INSTRUCTION_EXECUTOR_UNIT_MACROS_SVH
`define STACK_VM_INSTRUCTION_EXECUTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SVIE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("svie assertion failed");
`define SVIE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("svie assertion failed");
`else
`define SVIE_ASSERT_NOW(lbl, ante, cons)
`define SVIE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/svie_pkg.sv =====
// Package for the stack machine executor: word types, opcodes and status codes.
// No dependencies.
package svie_pkg;

  localparam int unsigned StackDepthDefault = 1024;
  localparam int unsigned XW = 34;
  localparam logic [31:0] RetLimit = 32'h0000_0200;

  localparam logic [4:0] OpBreak  = 5'd0;
  localparam logic [4:0] OpNop    = 5'd1;
  localparam logic [4:0] OpCall   = 5'd2;
  localparam logic [4:0] OpPush0  = 5'd3;
  localparam logic [4:0] OpPushI  = 5'd4;
  localparam logic [4:0] OpRet    = 5'd5;
  localparam logic [4:0] OpPop    = 5'd6;
  localparam logic [4:0] OpSwap   = 5'd7;
  localparam logic [4:0] OpSetup  = 5'd8;
  localparam logic [4:0] OpRestore = 5'd9;
  localparam logic [4:0] OpNative = 5'd10;
  localparam logic [4:0] OpSelf   = 5'd11;
  localparam logic [4:0] OpArgChk = 5'd12;
  localparam logic [4:0] OpBranch = 5'd13;
  localparam logic [4:0] OpBrTrue = 5'd14;
  localparam logic [4:0] OpBrFalse = 5'd15;
  localparam logic [4:0] OpResume = 5'd16;

  localparam logic CfgTrue  = 1'b0;
  localparam logic CfgFalse = 1'b1;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StBreak   = 3'd1,
    StInvalid = 3'd2,
    StArgCnt  = 3'd3,
    StRetSent = 3'd4,
    StCall    = 3'd5,
    StStack   = 3'd6,
    StHalted  = 3'd7
  } status_e;

  typedef struct packed {
    logic [4:0]  command;
    logic [31:0] operand;
  } in_word_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [2:0]  status;
    logic [31:0] top_value;
    logic [9:0]  stack_index;
    logic [9:0]  frame_index;
  } out_word_t;

endpackage

// ===== design/svie_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module svie_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/stack_vm_instruction_executor_unit.sv =====
// Top level of the stack machine executor: sequencer, registers and stack memory.
// Depends on svie_pkg, svie_ram and the assertion macro header.
//
// One word is taken at a time and yields one result word. An instruction goes
// through S_DEC, any stack reads (S_RD, S_RDW) and S_EVAL, any stack writes
// (S_WR; a return makes three reads and one write, a swap two reads and two
// writes), S_FILL for a frame setup, which clears its locals one write each,
// and S_TOP and S_TOPW. The sequence is set by the single port of the stack
// memory, which serves one read or one write per cycle, followed by a read of
// the new top of stack. A stalled output holds the sequencer in S_TOPW. A new
// word is taken as soon as the previous result is in the output register.
`include "stack_vm_instruction_executor_unit_macros.svh"
module stack_vm_instruction_executor_unit #(
  parameter int unsigned STACK_DEPTH = svie_pkg::StackDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  svie_pkg::in_word_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output svie_pkg::out_word_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import svie_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam logic [XW-1:0] DX = XW'(STACK_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_RD   = 9'b000000100,
    S_RDW  = 9'b000001000,
    S_EVAL = 9'b000010000,
    S_WR   = 9'b000100000,
    S_FILL = 9'b001000000,
    S_TOP  = 9'b010000000,
    S_TOPW = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] pc_q, pc_d;
  logic [AW-1:0] sp_q, sp_d, fp_q, fp_d;
  logic halted_q, halted_d;
  status_e st_q, st_d;
  logic [31:0] true_q, false_q;
  logic [4:0] cmd_q;
  logic [31:0] opnd_q;
  logic [AW-1:0] ra_q [3];
  logic [AW-1:0] ra_d [3];
  logic [1:0] nrd_q, nrd_d, rd_i_q, rd_i_d;
  logic rd_pend_q, rd_pend_d;
  logic [1:0] rd_slot_q, rd_slot_d;
  logic [31:0] r_q [3];
  logic [AW-1:0] wa_q [2];
  logic [AW-1:0] wa_d [2];
  logic [31:0] wd_q [2];
  logic [31:0] wd_d [2];
  logic [1:0] nwr_q, nwr_d;
  logic wr_i_q, wr_i_d;
  logic [AW-1:0] fill_cnt_q, fill_cnt_d, fill_addr_q, fill_addr_d;
  logic top_ok_q, top_ok_d;
  logic out_valid_q;
  out_word_t out_q;

  logic mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_wdata, mem_rdata;
  logic [XW-1:0] spx, fpx, jx, topx;
  logic [31:0] sp_ext, fp_ext;

  assign spx = XW'(sp_q);
  assign fpx = XW'(fp_q);
  assign jx = XW'(opnd_q);
  assign topx = spx + XW'(1);

  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_comb begin
    state_d = state_q;
    pc_d = pc_q;
    sp_d = sp_q;
    fp_d = fp_q;
    halted_d = halted_q;
    st_d = st_q;
    ra_d = ra_q;
    nrd_d = nrd_q;
    rd_i_d = rd_i_q;
    rd_pend_d = 1'b0;
    rd_slot_d = rd_slot_q;
    wa_d = wa_q;
    wd_d = wd_q;
    nwr_d = nwr_q;
    wr_i_d = wr_i_q;
    fill_cnt_d = fill_cnt_q;
    fill_addr_d = fill_addr_q;
    top_ok_d = top_ok_q;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_addr = sp_q;
    mem_wdata = wd_q[wr_i_q];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        st_d = StOk;
        nrd_d = 2'd0;
        nwr_d = 2'd0;
        rd_i_d = 2'd0;
        wr_i_d = 1'b0;
        fill_cnt_d = '0;
        if (cmd_q == OpResume) begin
          pc_d = opnd_q;
          halted_d = 1'b0;
        end else if (halted_q) begin
          st_d = StHalted;
        end else begin
          case (cmd_q)
            OpBreak: begin
              halted_d = 1'b1;
              st_d = StBreak;
            end
            OpNop: pc_d = pc_q + 32'd1;
            OpNative: pc_d = pc_q + 32'd5;
            OpBranch: pc_d = pc_q + 32'd5 + opnd_q;
            OpCall, OpPush0, OpPushI: begin
              if (sp_q == '0) begin
                halted_d = 1'b1;
                st_d = StStack;
              end else begin
                nwr_d = 2'd1;
                wa_d[0] = sp_q;
                wd_d[0] = (cmd_q == OpCall) ? pc_q + 32'd1 :
                          (cmd_q == OpPushI) ? opnd_q : 32'd0;
                sp_d = sp_q - AW'(1);
                pc_d = pc_q + ((cmd_q == OpPushI) ? 32'd5 : 32'd1);
                if (cmd_q == OpCall) begin
                  st_d = StCall;
                end
              end
            end
            OpRet: begin
              if (!(spx + XW'(5) < DX) || !(spx + XW'(4) + jx < DX)) begin
                halted_d = 1'b1;
                st_d = StStack;
              end else begin
                nrd_d = 2'd3;
                ra_d[0] = sp_q + AW'(1);
                ra_d[1] = sp_q + AW'(4);
                ra_d[2] = sp_q + AW'(5);
              end
            end
            OpPop: begin
              if (!(topx < DX)) begin
                halted_d = 1'b1;
                st_d = StStack;
              end else begin
                sp_d = sp_q + AW'(1);
                pc_d = pc_q + 32'd1;
              end
            end
            OpSwap: begin
              if (!(spx + XW'(2) < DX)) begin
                halted_d = 1'b1;
                st_d = StStack;
              end else begin
                nrd_d = 2'd2;
                ra_d[0] = sp_q + AW'(1);
                ra_d[1] = sp_q + AW'(2);
              end
            end
            OpSetup: begin
              if (spx < jx + XW'(1)) begin
                halted_d = 1'b1;
                st_d = StStack;
              end else begin
                nwr_d = 2'd1;
                wa_d[0] = sp_q;
                wd_d[0] = 32'(fp_q);
                fp_d = sp_q - AW'(1);
                sp_d = sp_q - AW'(1) - opnd_q[AW-1:0];
                fill_cnt_d = opnd_q[AW-1:0];
                fill_addr_d = sp_q - AW'(1);
                pc_d = pc_q + 32'd5;
              end
            end
            OpRestore: begin
              if (!(topx < DX) || !(fpx + XW'(1) < DX)) begin
                halted_d = 1'b1;
                st_d = StStack;
              end else begin
                nrd_d = 2'd2;
                ra_d[0] = sp_q + AW'(1);
                ra_d[1] = fp_q + AW'(1);
              end
            end
            OpSelf: begin
              if (!(fpx + XW'(2) < DX) || sp_q == '0) begin
                halted_d = 1'b1;
                st_d = StStack;
              end else begin
                nrd_d = 2'd1;
                ra_d[0] = fp_q + AW'(2);
              end
            end
            OpArgChk: begin
              if (!(spx + XW'(3) < DX)) begin
                halted_d = 1'b1;
                st_d = StStack;
              end else begin
                nrd_d = 2'd1;
                ra_d[0] = sp_q + AW'(3);
              end
            end
            OpBrTrue, OpBrFalse: begin
              if (!(topx < DX)) begin
                halted_d = 1'b1;
                st_d = StStack;
              end else begin
                nrd_d = 2'd1;
                ra_d[0] = sp_q + AW'(1);
              end
            end
            default: begin
              halted_d = 1'b1;
              st_d = StInvalid;
            end
          endcase
        end
        if (nrd_d != 2'd0) begin
          state_d = S_RD;
        end else if (nwr_d != 2'd0) begin
          state_d = S_WR;
        end else begin
          state_d = S_TOP;
        end
      end
      S_RD: begin
        mem_re = 1'b1;
        mem_addr = ra_q[rd_i_q];
        rd_pend_d = 1'b1;
        rd_slot_d = rd_i_q;
        if (rd_i_q == nrd_q - 2'd1) begin
          state_d = S_RDW;
        end else begin
          rd_i_d = rd_i_q + 2'd1;
        end
      end
      S_RDW: state_d = S_EVAL;
      S_EVAL: begin
        case (cmd_q)
          OpRet: begin
            nwr_d = 2'd1;
            wa_d[0] = sp_q + AW'(4) + opnd_q[AW-1:0];
            wd_d[0] = r_q[0];
            pc_d = r_q[1];
            sp_d = sp_q + AW'(3) + opnd_q[AW-1:0];
            if (!r_q[2][31] && (r_q[2] > RetLimit)) begin
              halted_d = 1'b1;
              st_d = StRetSent;
            end
          end
          OpSwap: begin
            nwr_d = 2'd2;
            wa_d[0] = sp_q + AW'(1);
            wd_d[0] = r_q[1];
            wa_d[1] = sp_q + AW'(2);
            wd_d[1] = r_q[0];
            pc_d = pc_q + 32'd1;
          end
          OpRestore: begin
            if (!({2'b00, r_q[1]} < DX)) begin
              halted_d = 1'b1;
              st_d = StStack;
            end else begin
              nwr_d = 2'd1;
              wa_d[0] = fp_q + AW'(1);
              wd_d[0] = r_q[0];
              sp_d = fp_q;
              fp_d = r_q[1][AW-1:0];
              pc_d = pc_q + 32'd1;
            end
          end
          OpSelf: begin
            nwr_d = 2'd1;
            wa_d[0] = sp_q;
            wd_d[0] = r_q[0];
            sp_d = sp_q - AW'(1);
            pc_d = pc_q + 32'd1;
          end
          OpArgChk: begin
            pc_d = pc_q + 32'd5;
            if (r_q[0] != opnd_q) begin
              halted_d = 1'b1;
              st_d = StArgCnt;
            end
          end
          default: begin
            sp_d = sp_q + AW'(1);
            pc_d = pc_q + 32'd5 +
                   ((r_q[0] == ((cmd_q == OpBrTrue) ? true_q : false_q)) ? opnd_q : 32'd0);
          end
        endcase
        state_d = (nwr_d != 2'd0) ? S_WR : S_TOP;
      end
      S_WR: begin
        mem_we = 1'b1;
        mem_addr = wa_q[wr_i_q];
        if ({1'b0, wr_i_q} == nwr_q - 2'd1) begin
          state_d = (fill_cnt_q != '0) ? S_FILL : S_TOP;
        end else begin
          wr_i_d = 1'b1;
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        mem_addr = fill_addr_q;
        mem_wdata = 32'd0;
        fill_addr_d = fill_addr_q - AW'(1);
        fill_cnt_d = fill_cnt_q - AW'(1);
        if (fill_cnt_q == AW'(1)) begin
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        top_ok_d = topx < DX;
        mem_re = topx < DX;
        mem_addr = sp_q + AW'(1);
        state_d = S_TOPW;
      end
      S_TOPW: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign sp_ext = 32'(sp_q);
  assign fp_ext = 32'(fp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= '0;
      sp_q <= AW'(STACK_DEPTH - 1);
      fp_q <= '0;
      halted_q <= 1'b0;
      st_q <= StOk;
      true_q <= '0;
      false_q <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q <= 1'b0;
      nrd_q <= '0;
      nwr_q <= '0;
      rd_i_q <= '0;
      wr_i_q <= 1'b0;
      fill_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      sp_q <= sp_d;
      fp_q <= fp_d;
      halted_q <= halted_d;
      st_q <= st_d;
      rd_pend_q <= rd_pend_d;
      nrd_q <= nrd_d;
      nwr_q <= nwr_d;
      rd_i_q <= rd_i_d;
      wr_i_q <= wr_i_d;
      fill_cnt_q <= fill_cnt_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgTrue) begin
          true_q <= cfg_data_i;
        end else begin
          false_q <= cfg_data_i;
        end
      end
      if (state_q == S_TOPW && state_d == S_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q <= in_data_i.command;
      opnd_q <= in_data_i.operand;
    end
    ra_q <= ra_d;
    wa_q <= wa_d;
    wd_q <= wd_d;
    rd_slot_q <= rd_slot_d;
    fill_addr_q <= fill_addr_d;
    top_ok_q <= top_ok_d;
    if (rd_pend_q) begin
      r_q[rd_slot_q] <= mem_rdata;
    end
    if (state_q == S_TOPW && state_d == S_IDLE) begin
      out_q.next_pc <= pc_q;
      out_q.status <= st_q;
      out_q.top_value <= top_ok_q ? mem_rdata : 32'd0;
      out_q.stack_index <= sp_ext[9:0];
      out_q.frame_index <= fp_ext[9:0];
    end
  end

  svie_ram #(
    .Width(32),
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  `SVIE_ASSERT_NEXT(a_accept_decodes, in_valid_i && !in_stall_o, state_q == S_DEC)
  `SVIE_ASSERT_NOW(a_idle_no_write, state_q == S_IDLE, !mem_we)
  `SVIE_ASSERT_NOW(a_sp_in_range, 1'b1, XW'(sp_q) < DX)
  `SVIE_ASSERT_NOW(a_fill_nonzero, state_q == S_FILL, fill_cnt_q != '0)
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the stack machine instruction executor.
// Depends on svie_pkg and the executor RTL. A shadow copy of the machine plans
// legal instruction streams, and a second copy predicts every result word.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import svie_pkg::*;

  localparam int unsigned Depth = StackDepthDefault;

  typedef struct {
    logic [31:0] mem [Depth];
    bit          wr [Depth];
    logic [31:0] pc;
    longint unsigned sp;
    longint unsigned fp;
    bit          halted;
    logic [31:0] tv;
    logic [31:0] fv;
  } vm_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CfgTrue;
  logic [31:0] cfg_data = '0;

  vm_t plan_vm, trial_vm, pred_vm;
  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int errors = 0;
  bit in_took = 1'b0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;

  stack_vm_instruction_executor_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void vm_clear(ref vm_t s);
    for (int i = 0; i < Depth; i++) begin
      s.mem[i] = '0;
      s.wr[i] = 1'b0;
    end
    s.pc = '0;
    s.sp = Depth - 1;
    s.fp = 0;
    s.halted = 1'b0;
    s.tv = '0;
    s.fv = '0;
  endfunction

  function automatic logic [31:0] vm_rd(ref vm_t s, input longint unsigned i, ref bit bad);
    if (!s.wr[i]) bad = 1'b1;
    return s.mem[i];
  endfunction

  function automatic void vm_wr(ref vm_t s, input longint unsigned i, input logic [31:0] v);
    s.mem[i] = v;
    s.wr[i] = 1'b1;
  endfunction

  // Executes one word; bad is set when an entry never written would be read.
  function automatic void vm_step(ref vm_t s, input in_word_t w, output out_word_t r,
                                  output bit bad);
    status_e st;
    longint unsigned sp, fp, j;
    logic [31:0] v, t, npc, op;
    logic [4:0] cmd;
    bad = 1'b0;
    st = StOk;
    sp = s.sp;
    fp = s.fp;
    cmd = w.command;
    op = w.operand;
    j = op;
    if (cmd == OpResume) begin
      s.pc = op;
      s.halted = 1'b0;
    end else if (s.halted) begin
      st = StHalted;
    end else begin
      case (cmd)
        OpBreak: begin
          s.halted = 1'b1;
          st = StBreak;
        end
        OpNop: s.pc = s.pc + 32'd1;
        OpNative: s.pc = s.pc + 32'd5;
        OpCall, OpPush0, OpPushI: begin
          if (sp == 0) st = StStack;
          else begin
            vm_wr(s, sp, (cmd == OpCall) ? s.pc + 32'd1 : (cmd == OpPush0) ? 32'd0 : op);
            s.sp = sp - 1;
            s.pc = s.pc + ((cmd == OpPushI) ? 32'd5 : 32'd1);
            if (cmd == OpCall) st = StCall;
          end
        end
        OpRet: begin
          if (sp + 5 >= Depth || sp + 4 + j >= Depth) st = StStack;
          else begin
            v = vm_rd(s, sp + 1, bad);
            npc = vm_rd(s, sp + 4, bad);
            t = vm_rd(s, sp + 5, bad);
            vm_wr(s, sp + 4 + j, v);
            s.sp = sp + 3 + j;
            s.pc = npc;
            if (t < 32'h8000_0000 && t > RetLimit) begin
              s.halted = 1'b1;
              st = StRetSent;
            end
          end
        end
        OpPop: begin
          if (sp + 1 >= Depth) st = StStack;
          else begin
            s.sp = sp + 1;
            s.pc = s.pc + 32'd1;
          end
        end
        OpSwap: begin
          if (sp + 2 >= Depth) st = StStack;
          else begin
            v = vm_rd(s, sp + 1, bad);
            t = vm_rd(s, sp + 2, bad);
            vm_wr(s, sp + 1, t);
            vm_wr(s, sp + 2, v);
            s.pc = s.pc + 32'd1;
          end
        end
        OpSetup: begin
          if (sp < j + 1) st = StStack;
          else begin
            vm_wr(s, sp, fp[31:0]);
            s.fp = sp - 1;
            for (longint unsigned k = 1; k <= j; k++) vm_wr(s, sp - k, 32'd0);
            s.sp = sp - 1 - j;
            s.pc = s.pc + 32'd5;
          end
        end
        OpRestore: begin
          if (sp + 1 >= Depth || fp + 1 >= Depth) st = StStack;
          else begin
            v = vm_rd(s, sp + 1, bad);
            t = vm_rd(s, fp + 1, bad);
            if (t >= Depth) st = StStack;
            else begin
              vm_wr(s, fp + 1, v);
              s.sp = fp;
              s.fp = t;
              s.pc = s.pc + 32'd1;
            end
          end
        end
        OpSelf: begin
          if (fp + 2 >= Depth || sp == 0) st = StStack;
          else begin
            vm_wr(s, sp, vm_rd(s, fp + 2, bad));
            s.sp = sp - 1;
            s.pc = s.pc + 32'd1;
          end
        end
        OpArgChk: begin
          if (sp + 3 >= Depth) st = StStack;
          else begin
            s.pc = s.pc + 32'd5;
            if (vm_rd(s, sp + 3, bad) != op) begin
              s.halted = 1'b1;
              st = StArgCnt;
            end
          end
        end
        OpBranch: s.pc = s.pc + 32'd5 + op;
        OpBrTrue, OpBrFalse: begin
          if (sp + 1 >= Depth) st = StStack;
          else begin
            v = vm_rd(s, sp + 1, bad);
            s.sp = sp + 1;
            s.pc = s.pc + 32'd5;
            if (v == ((cmd == OpBrTrue) ? s.tv : s.fv)) s.pc = s.pc + op;
          end
        end
        default: begin
          s.halted = 1'b1;
          st = StInvalid;
        end
      endcase
      if (st == StStack) s.halted = 1'b1;
    end
    r.next_pc = s.pc;
    r.status = st;
    r.top_value = (s.sp + 1 < Depth) ? vm_rd(s, s.sp + 1, bad) : 32'd0;
    r.stack_index = s.sp[9:0];
    r.frame_index = s.fp[9:0];
  endfunction

  // Queues a word if it is legal on the planning copy, else a safe resume.
  task automatic offer(input in_word_t w);
    out_word_t r;
    bit bad;
    trial_vm = plan_vm;
    vm_step(trial_vm, w, r, bad);
    if (bad) begin
      w.command = OpResume;
      w.operand = $urandom;
      trial_vm = plan_vm;
      vm_step(trial_vm, w, r, bad);
    end
    plan_vm = trial_vm;
    pending_words.push_back(w);
  endtask

  function automatic in_word_t mk(input logic [4:0] c, input logic [31:0] o);
    in_word_t w;
    w.command = c;
    w.operand = o;
    return w;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return plan_vm.tv;
      1: return plan_vm.fv;
      2: return $urandom_range(16'h400, 0);
      3: return 32'h0000_0201;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t random_word();
    int r;
    logic [31:0] o;
    r = $urandom_range(99);
    o = $urandom;
    if (plan_vm.halted && $urandom_range(99) < 80) return mk(OpResume, o);
    if (r < 25) return mk(OpPushI, pick_value());
    if (r < 32) return mk(OpPush0, o);
    if (r < 38) return mk(OpCall, o);
    if (r < 46) return mk(OpPop, o);
    if (r < 52) return mk(OpSwap, o);
    if (r < 58) return mk(OpSetup, ($urandom_range(19) == 0) ? o : $urandom_range(3));
    if (r < 64) return mk(OpRestore, o);
    if (r < 68) return mk(OpRet, ($urandom_range(19) == 0) ? o : $urandom_range(3));
    if (r < 72) return mk(OpSelf, o);
    if (r < 76) begin
      if (plan_vm.sp + 3 < Depth && plan_vm.wr[plan_vm.sp + 3] && $urandom_range(9) < 7)
        o = plan_vm.mem[plan_vm.sp + 3];
      return mk(OpArgChk, o);
    end
    if (r < 79) return mk(OpBranch, o);
    if (r < 86) return mk(OpBrTrue, o);
    if (r < 92) return mk(OpBrFalse, o);
    if (r < 94) return mk(OpNop, o);
    if (r < 96) return mk(OpNative, o);
    if (r < 97) return mk(OpBreak, o);
    return mk(5'($urandom_range(31, 17)), o);
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CfgTrue) begin
      plan_vm.tv = val;
      pred_vm.tv = val;
    end else begin
      plan_vm.fv = val;
      pred_vm.fv = val;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_word_t r;
    out_word_t e;
    bit bad;
    in_took = in_valid && !in_stall && rst_ni;
    if (in_took) begin
      vm_step(pred_vm, in_data, r, bad);
      expected_words.push_back(r);
    end
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        flag_mismatch("unexpected word", out_data.next_pc, '0);
      end else begin
        e = expected_words.pop_front();
        if (out_data.next_pc !== e.next_pc)
          flag_mismatch("next_pc", out_data.next_pc, e.next_pc);
        if (out_data.status !== e.status)
          flag_mismatch("status", 32'(out_data.status), 32'(e.status));
        if (out_data.top_value !== e.top_value)
          flag_mismatch("top_value", out_data.top_value, e.top_value);
        if (out_data.stack_index !== e.stack_index)
          flag_mismatch("stack_index", 32'(out_data.stack_index), 32'(e.stack_index));
        if (out_data.frame_index !== e.frame_index)
          flag_mismatch("frame_index", 32'(out_data.frame_index), 32'(e.frame_index));
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 9);
    end
  end

  initial begin
    #5ms;
    $display("FAIL stack_vm_instruction_executor_unit");
    $finish;
  end

  initial begin
    vm_clear(plan_vm);
    vm_clear(pred_vm);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    offer(mk(OpNop, 32'hFFFF_FFFF));
    offer(mk(OpBreak, 32'h0));
    offer(mk(OpPushI, 32'h1234_5678));
    offer(mk(OpResume, 32'h0000_0100));
    offer(mk(5'd17, 32'h0));
    offer(mk(OpResume, 32'h0));
    offer(mk(5'd31, 32'h0));
    offer(mk(OpResume, 32'hFFFF_FFFF));
    offer(mk(OpNative, 32'h0));
    offer(mk(OpPop, 32'h0));
    offer(mk(OpResume, 32'h0));
    offer(mk(OpSetup, 32'h0));
    offer(mk(OpPushI, 32'd5000));
    offer(mk(OpSwap, 32'h0));
    offer(mk(OpRestore, 32'h0));
    offer(mk(OpResume, 32'h0));
    offer(mk(OpSetup, 32'hFFFF_FFFF));
    offer(mk(OpResume, 32'h0));
    offer(mk(OpPushI, 32'h0000_0201));
    offer(mk(OpPushI, 32'h0000_1234));
    offer(mk(OpPushI, 32'hFFFF_FFFF));
    offer(mk(OpPush0, 32'h0));
    offer(mk(OpCall, 32'h0));
    offer(mk(OpRet, 32'h0));
    offer(mk(OpResume, 32'h40));
    offer(mk(OpArgChk, 32'h0));
    offer(mk(OpBranch, 32'h7FFF_FFFF));
    offer(mk(OpBrTrue, 32'h8000_0000));
    wait_drained();

    write_reg(CfgTrue, 32'hFFFF_FFFF);
    write_reg(CfgFalse, 32'h0);
    hold_go = 1'b1;
    for (int i = 0; i < 500; i++) offer(random_word());
    wait_drained();

    write_reg(CfgTrue, $urandom_range(16'h400, 0));
    write_reg(CfgFalse, $urandom);
    calm = 1'b1;
    while (!(plan_vm.sp == 0 && plan_vm.halted)) begin
      if (plan_vm.halted) offer(mk(OpResume, $urandom));
      else offer(mk(OpPushI, pick_value()));
    end
    offer(mk(OpResume, 32'h0));
    for (int i = 0; i < 60; i++) offer(random_word());
    wait_drained();
    calm = 1'b0;

    write_reg(CfgTrue, 32'h0);
    write_reg(CfgFalse, 32'hFFFF_FFFF);
    vm_clear(trial_vm);
    for (int i = 0; i < 400; i++) offer(random_word());
    wait_drained();
    repeat (50) @(posedge clk_i);

    while (expected_words.size() != 0) begin
      e_left: flag_mismatch("missing word", expected_words[0].next_pc, '0);
      void'(expected_words.pop_front());
    end
    if (errors == 0) begin
      $display("PASS stack_vm_instruction_executor_unit");
    end else begin
      $display("FAIL stack_vm_instruction_executor_unit");
    end
    $finish;
  end
endmodule
